// ===== hw/rtl/u16u8_pkg.sv =====
// shared types, constants and byte-encoding function for the utf-16 to utf-8 encoder
// no dependencies; imported by the front, queue, back and top level modules

package u16u8_pkg;

    // code unit ranges and utf-8 lead patterns
    localparam logic [15:0] HIGH_SURR_LO = 16'hD800;
    localparam logic [15:0] HIGH_SURR_HI = 16'hDBFF;
    localparam logic [15:0] LOW_SURR_LO  = 16'hDC00;
    localparam logic [15:0] LOW_SURR_HI  = 16'hDFFF;
    localparam logic [20:0] SUPP_BASE    = 21'h10000;
    localparam logic [15:0] LIMIT_1BYTE  = 16'h0080;
    localparam logic [15:0] LIMIT_2BYTE  = 16'h0800;
    localparam logic [7:0]  LEAD_2BYTE   = 8'hC0;
    localparam logic [7:0]  LEAD_3BYTE   = 8'hE0;
    localparam logic [7:0]  LEAD_4BYTE   = 8'hF0;
    localparam logic [7:0]  CONT_BYTE    = 8'h80;

    // sequence length codes (length minus one)
    localparam logic [1:0] LEN_1 = 2'd0;
    localparam logic [1:0] LEN_2 = 2'd1;
    localparam logic [1:0] LEN_3 = 2'd2;
    localparam logic [1:0] LEN_4 = 2'd3;

    // bytes of a flushed lone high surrogate
    localparam logic [2:0] PRE_BYTES = 3'd3;

    // front to back queue
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // one job: an optional flushed high surrogate, then an optional code point
    typedef struct packed {
        logic        pre_valid;
        logic [9:0]  pre_bits;
        logic        main_valid;
        logic [20:0] main_code;
        logic [1:0]  main_len_m1;
        logic        eot;
    } job_t;

    // byte idx of the utf-8 sequence of length len_m1+1 for code point c
    function automatic logic [7:0] enc_byte(input logic [20:0] c,
                                            input logic [1:0]  len_m1,
                                            input logic [1:0]  idx);
        logic [1:0] pos;
        logic [7:0] b;
        pos = len_m1 - idx;
        if (idx == 2'd0)
        begin
            case (len_m1)
                LEN_1:   b = {1'b0, c[6:0]};
                LEN_2:   b = LEAD_2BYTE | {3'b000, c[10:6]};
                LEN_3:   b = LEAD_3BYTE | {4'b0000, c[15:12]};
                LEN_4:   b = LEAD_4BYTE | {5'b00000, c[20:18]};
                default: b = {1'b0, c[6:0]};
            endcase
        end
        else
        begin
            case (pos)
                2'd0:    b = CONT_BYTE | {2'b00, c[5:0]};
                2'd1:    b = CONT_BYTE | {2'b00, c[11:6]};
                2'd2:    b = CONT_BYTE | {2'b00, c[17:12]};
                default: b = CONT_BYTE | {2'b00, c[5:0]};
            endcase
        end
        return b;
    endfunction

endpackage

// ===== hw/rtl/u16u8_if.sv =====
// valid/ready channel interfaces for utf-16 code units and utf-8 bytes
// no dependencies beyond the language; used by the front, back and top level

interface u16u8_unit_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic        end_of_text;

    modport source (output valid, output code_unit, output end_of_text, input ready);
    modport sink   (input valid, input code_unit, input end_of_text, output ready);
endinterface

interface u16u8_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] utf8_byte;
    logic       run_last;
    logic       text_last;

    modport source (output valid, output utf8_byte, output run_last, output text_last,
                    input ready);
    modport sink   (input valid, input utf8_byte, input run_last, input text_last,
                    output ready);
endinterface

// ===== hw/rtl/u16u8_front.sv =====
// front end: accepts code units, pairs surrogates and pushes encoding jobs
// depends on u16u8_pkg and u16u8_unit_if

module u16u8_front (
    input  logic                 clk,
    input  logic                 rst_n,
    u16u8_unit_if.sink           unit_in,
    output logic                 push_valid,
    output u16u8_pkg::job_t      push_job,
    input  logic                 push_ready
);
    import u16u8_pkg::*;

    logic       held_valid_reg;
    logic       held_valid_next;
    logic [9:0] held_bits_reg;
    logic [9:0] held_bits_next;
    logic       is_high;
    logic       is_low;
    logic       accept;
    logic       hold_now;
    logic [1:0] unit_len_m1;
    job_t       job;

    // classify the incoming unit
    always_comb
    begin
        is_high = (unit_in.code_unit >= HIGH_SURR_LO) && (unit_in.code_unit <= HIGH_SURR_HI);
        is_low  = (unit_in.code_unit >= LOW_SURR_LO) && (unit_in.code_unit <= LOW_SURR_HI);
        if (unit_in.code_unit < LIMIT_1BYTE)
            unit_len_m1 = LEN_1;
        else if (unit_in.code_unit < LIMIT_2BYTE)
            unit_len_m1 = LEN_2;
        else
            unit_len_m1 = LEN_3;
    end

    // build the job for this beat
    always_comb
    begin
        job          = '0;
        job.eot      = unit_in.end_of_text;
        job.pre_bits = held_bits_reg;
        hold_now     = 1'b0;
        if (held_valid_reg && is_low)
        begin
            job.main_valid  = 1'b1;
            job.main_code   = SUPP_BASE + {1'b0, held_bits_reg, unit_in.code_unit[9:0]};
            job.main_len_m1 = LEN_4;
        end
        else
        begin
            job.pre_valid = held_valid_reg;
            if (is_high && !unit_in.end_of_text)
                hold_now = 1'b1;
            else
            begin
                job.main_valid  = 1'b1;
                job.main_code   = {5'b00000, unit_in.code_unit};
                job.main_len_m1 = unit_len_m1;
            end
        end
    end

    assign unit_in.ready = push_ready;
    assign accept        = unit_in.valid && push_ready;
    assign push_valid    = accept && (job.pre_valid || job.main_valid);
    assign push_job      = job;

    // held high surrogate
    always_comb
    begin
        held_valid_next = held_valid_reg;
        held_bits_next  = held_bits_reg;
        if (accept)
        begin
            held_valid_next = hold_now;
            held_bits_next  = hold_now ? unit_in.code_unit[9:0] : 10'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
            held_bits_reg  <= 10'd0;
        end
        else
        begin
            held_valid_reg <= held_valid_next;
            held_bits_reg  <= held_bits_next;
        end
    end

endmodule

// ===== hw/rtl/u16u8_queue.sv =====
// small job fifo between the front end and the byte sequencer
// depends on u16u8_pkg

module u16u8_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push_valid,
    input  u16u8_pkg::job_t      push_job,
    output logic                 push_ready,
    output logic                 pop_valid,
    output u16u8_pkg::job_t      pop_job,
    input  logic                 pop_ready
);
    import u16u8_pkg::*;

    job_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != QCNT_W'(QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

endmodule

// ===== hw/rtl/u16u8_back.sv =====
// byte sequencer: walks one job a byte at a time into a registered output beat
// depends on u16u8_pkg and u16u8_byte_if

module u16u8_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pop_valid,
    input  u16u8_pkg::job_t      pop_job,
    output logic                 pop_ready,
    u16u8_byte_if.source         byte_out
);
    import u16u8_pkg::*;

    job_t        cur_reg;
    job_t        cur_next;
    logic        cur_valid_reg;
    logic        cur_valid_next;
    logic [2:0]  step_reg;
    logic [2:0]  step_next;
    logic        ov_reg;
    logic        ov_next;
    logic [7:0]  obyte_reg;
    logic [7:0]  obyte_next;
    logic        orun_reg;
    logic        orun_next;
    logic        otext_reg;
    logic        otext_next;
    logic [2:0]  total_m1;
    logic        in_pre;
    logic [1:0]  main_idx;
    logic [20:0] pre_code;
    logic [7:0]  cur_byte;
    logic        is_last;
    logic        out_free;
    logic        emit;

    // position within the job
    always_comb
    begin
        if (cur_reg.pre_valid)
            total_m1 = cur_reg.main_valid ? (PRE_BYTES + {1'b0, cur_reg.main_len_m1})
                                          : (PRE_BYTES - 3'd1);
        else
            total_m1 = {1'b0, cur_reg.main_len_m1};
        in_pre   = cur_reg.pre_valid && (step_reg < PRE_BYTES);
        main_idx = cur_reg.pre_valid ? 2'(step_reg - PRE_BYTES) : step_reg[1:0];
        pre_code = {5'b00000, 6'b110110, cur_reg.pre_bits};
        cur_byte = in_pre ? enc_byte(pre_code, LEN_3, step_reg[1:0])
                          : enc_byte(cur_reg.main_code, cur_reg.main_len_m1, main_idx);
        is_last  = (step_reg == total_m1);
    end

    assign out_free  = !ov_reg || byte_out.ready;
    assign emit      = cur_valid_reg && out_free;
    assign pop_ready = !cur_valid_reg || (emit && is_last);

    // sequencer and output register
    always_comb
    begin
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        step_next      = step_reg;
        ov_next        = ov_reg;
        obyte_next     = obyte_reg;
        orun_next      = orun_reg;
        otext_next     = otext_reg;
        if (byte_out.ready)
            ov_next = 1'b0;
        if (emit)
        begin
            ov_next    = 1'b1;
            obyte_next = cur_byte;
            orun_next  = is_last;
            otext_next = is_last && cur_reg.eot;
            step_next  = step_reg + 3'd1;
            if (is_last)
                cur_valid_next = 1'b0;
        end
        if (pop_valid && pop_ready)
        begin
            cur_next       = pop_job;
            cur_valid_next = 1'b1;
            step_next      = 3'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            step_reg      <= 3'd0;
            ov_reg        <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            step_reg      <= step_next;
            ov_reg        <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        obyte_reg <= obyte_next;
        orun_reg  <= orun_next;
        otext_reg <= otext_next;
    end

    assign byte_out.valid     = ov_reg;
    assign byte_out.utf8_byte = obyte_reg;
    assign byte_out.run_last  = orun_reg;
    assign byte_out.text_last = otext_reg;

endmodule

// ===== hw/rtl/utf16_to_utf8_stream_encoder_unit.sv =====
// utf-16 to utf-8 stream encoder, top level: front end, job queue, byte sequencer
// a unit's first byte passes through its queue entry, the sequencer's job register and the output register
// the sequencer emits one output byte per cycle while byte_out is ready, so a unit gives 1 to 3
// bytes (4 for a surrogate pair, up to 6 when a held unit is flushed)
// input beats are taken every cycle while the two-entry job queue has room
// reset (async, active low) empties the queue and drops any held high surrogate

module utf16_to_utf8_stream_encoder_unit (
    input  logic          clk,
    input  logic          rst_n,
    u16u8_unit_if.sink    code_in,
    u16u8_byte_if.source  byte_out
);
    import u16u8_pkg::*;

    logic push_valid;
    logic push_ready;
    job_t push_job;
    logic pop_valid;
    logic pop_ready;
    job_t pop_job;

    // classify units and pair surrogates
    u16u8_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .unit_in    (code_in),
        .push_valid (push_valid),
        .push_job   (push_job),
        .push_ready (push_ready)
    );

    // decouple front end from byte output
    u16u8_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_job   (push_job),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_job    (pop_job),
        .pop_ready  (pop_ready)
    );

    // emit bytes
    u16u8_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_job   (pop_job),
        .pop_ready (pop_ready),
        .byte_out  (byte_out)
    );

endmodule

// ===== tb/sv/utf16_to_utf8_stream_encoder_unit_tb_pkg.sv =====
// byte scoreboard for the utf-16 to utf-8 encoder testbench
// depends on u16u8_pkg for the surrogate and lead byte constants

package u16u8_tb_pkg;

    import u16u8_pkg::*;

    class utf8_byte_scoreboard;

        typedef struct packed {
            logic [7:0] utf8_byte;
            logic       run_last;
            logic       text_last;
        } utf8_exp_t;

        utf8_exp_t  pending[$];
        logic [9:0] held_bits;
        bit         held;
        int         errors;
        int         units_seen;
        int         bytes_seen;
        int         pairs_seen;
        int         flushes_seen;

        function new();
            held_bits    = '0;
            held         = 1'b0;
            errors       = 0;
            units_seen   = 0;
            bytes_seen   = 0;
            pairs_seen   = 0;
            flushes_seen = 0;
        endfunction

        // append one expected byte, flags filled in later
        function void push_byte(logic [7:0] b);
            utf8_exp_t e;
            e.utf8_byte = b;
            e.run_last  = 1'b0;
            e.text_last = 1'b0;
            pending.insert(pending.size(), e);
        endfunction

        // utf-8 bytes of one code point
        function void push_code(logic [20:0] c);
            if (c < 21'(LIMIT_1BYTE))
            begin
                push_byte({1'b0, c[6:0]});
            end
            else if (c < 21'(LIMIT_2BYTE))
            begin
                push_byte(LEAD_2BYTE | {3'b000, c[10:6]});
                push_byte(CONT_BYTE | {2'b00, c[5:0]});
            end
            else if (c < SUPP_BASE)
            begin
                push_byte(LEAD_3BYTE | {4'b0000, c[15:12]});
                push_byte(CONT_BYTE | {2'b00, c[11:6]});
                push_byte(CONT_BYTE | {2'b00, c[5:0]});
            end
            else
            begin
                push_byte(LEAD_4BYTE | {5'b00000, c[20:18]});
                push_byte(CONT_BYTE | {2'b00, c[17:12]});
                push_byte(CONT_BYTE | {2'b00, c[11:6]});
                push_byte(CONT_BYTE | {2'b00, c[5:0]});
            end
        endfunction

        // predict the bytes caused by one accepted code unit beat
        function void note_unit(logic [15:0] u, logic eot);
            int  first;
            bit  is_high;
            bit  is_low;
            bit  paired;
            first   = pending.size();
            is_high = (u >= HIGH_SURR_LO) && (u <= HIGH_SURR_HI);
            is_low  = (u >= LOW_SURR_LO) && (u <= LOW_SURR_HI);
            paired  = 1'b0;
            units_seen++;
            // a held high surrogate either pairs up or is flushed on its own
            if (held)
            begin
                held = 1'b0;
                if (is_low)
                begin
                    push_code(SUPP_BASE + {1'b0, held_bits, u[9:0]});
                    paired = 1'b1;
                    pairs_seen++;
                end
                else
                begin
                    push_code({5'b0, HIGH_SURR_LO | {6'b0, held_bits}});
                    flushes_seen++;
                end
                held_bits = '0;
            end
            // current unit, unless it completed a pair
            if (!paired)
            begin
                if (is_high && !eot)
                begin
                    held_bits = u[9:0];
                    held      = 1'b1;
                end
                else
                begin
                    push_code({5'b0, u});
                end
            end
            // mark the last byte of this beat
            if (pending.size() > first)
            begin
                pending[pending.size() - 1].run_last  = 1'b1;
                pending[pending.size() - 1].text_last = eot;
            end
        endfunction

        // compare one accepted output beat with the oldest expected byte
        function void check_byte(logic [7:0] b, logic rl, logic tl);
            utf8_exp_t e;
            bytes_seen++;
            if (pending.size() == 0)
            begin
                $error("unexpected byte %02h (run_last %0b, text_last %0b)", b, rl, tl);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (b !== e.utf8_byte)
            begin
                $error("utf8_byte mismatch: expected %02h, got %02h", e.utf8_byte, b);
                errors++;
            end
            if (rl !== e.run_last)
            begin
                $error("run_last mismatch: expected %0b, got %0b", e.run_last, rl);
                errors++;
            end
            if (tl !== e.text_last)
            begin
                $error("text_last mismatch: expected %0b, got %0b", e.text_last, tl);
                errors++;
            end
        endfunction

        function int expected_count();
            return pending.size();
        endfunction

    endclass

endpackage

// ===== tb/sv/utf16_to_utf8_stream_encoder_unit_tb.sv =====
// testbench top for the utf-16 to utf-8 stream encoder
// depends on u16u8_pkg, the channel interfaces, u16u8_tb_pkg and the encoder top level

module utf16_to_utf8_stream_encoder_unit_tb;

    import u16u8_pkg::*;
    import u16u8_tb_pkg::*;

    localparam int UNIT_TARGET = 420;
    localparam int CALM_AFTER  = 360;
    localparam int HOLD_AT     = 120;
    localparam int PAUSE_AT    = 240;
    localparam int LONG_HOLD   = 80;
    localparam int DRAIN_WAIT  = 20;
    localparam int CYCLE_LIMIT = 200000;

    logic clk;
    logic rst_n;

    u16u8_unit_if code_in ();
    u16u8_byte_if byte_out ();

    utf16_to_utf8_stream_encoder_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .code_in  (code_in),
        .byte_out (byte_out)
    );

    utf8_byte_scoreboard sb;
    bit idle_on;
    bit long_hold_req;
    int units_sent;
    int cycles;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // cycle limit
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("utf16_to_utf8_stream_encoder_unit_tb failed");
        $finish;
    end

    // byte receiver: check accepted beats, stall in bursts or for one long stretch
    initial
    begin
        int stall_left;
        stall_left = 0;
        byte_out.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && byte_out.valid && byte_out.ready)
            begin
                sb.check_byte(byte_out.utf8_byte, byte_out.run_last, byte_out.text_last);
            end
            if (!rst_n)
            begin
                byte_out.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                byte_out.ready <= 1'b0;
            end
            else if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                stall_left = LONG_HOLD - 1;
                byte_out.ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 5) - 1;
                byte_out.ready <= 1'b0;
            end
            else
            begin
                byte_out.ready <= 1'b1;
            end
        end
    end

    // offer one code unit beat and wait until it is taken
    task automatic send_unit(logic [15:0] u, logic eot);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            code_in.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        code_in.valid       <= 1'b1;
        code_in.code_unit   <= u;
        code_in.end_of_text <= eot;
        do
        begin
            @(posedge clk);
        end
        while (!code_in.ready);
        sb.note_unit(u, eot);
        units_sent++;
    endtask

    // one string of random symbols, mostly well formed, some lone surrogates and noise
    task automatic send_text(int n_sym);
        logic [15:0] units[$];
        int          k;
        int          r;
        for (k = 0; k < n_sym; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 25)
                units = {units, 16'($urandom_range(0, 16'h007F))};
            else if (r < 45)
                units = {units, 16'($urandom_range(16'h0080, 16'h07FF))};
            else if (r < 55)
                units = {units, 16'($urandom_range(16'h0800, 16'hD7FF))};
            else if (r < 62)
                units = {units, 16'($urandom_range(16'hE000, 16'hFFFF))};
            else if (r < 82)
            begin
                units = {units, 16'($urandom_range(HIGH_SURR_LO, HIGH_SURR_HI))};
                units = {units, 16'($urandom_range(LOW_SURR_LO, LOW_SURR_HI))};
            end
            else if (r < 88)
                units = {units, 16'($urandom_range(HIGH_SURR_LO, HIGH_SURR_HI))};
            else if (r < 93)
                units = {units, 16'($urandom_range(LOW_SURR_LO, LOW_SURR_HI))};
            else
                units = {units, 16'($urandom_range(0, 16'hFFFF))};
        end
        for (k = 0; k < units.size(); k++)
        begin
            send_unit(units[k], k == units.size() - 1);
        end
    endtask

    // main sequence
    initial
    begin
        bit hold_done;
        bit pause_done;
        sb            = new();
        idle_on       = 1'b1;
        long_hold_req = 1'b0;
        units_sent    = 0;
        hold_done     = 1'b0;
        pause_done    = 1'b0;
        rst_n               <= 1'b0;
        code_in.valid       <= 1'b0;
        code_in.code_unit   <= '0;
        code_in.end_of_text <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // range edges of one, two and three byte forms
        send_unit(16'h0000, 1'b0);
        send_unit(16'h007F, 1'b0);
        send_unit(16'h0080, 1'b0);
        send_unit(16'h07FF, 1'b0);
        send_unit(16'h0800, 1'b0);
        send_unit(16'hFFFF, 1'b1);
        // surrogate pairs at both ends
        send_unit(16'hD800, 1'b0);
        send_unit(16'hDC00, 1'b1);
        send_unit(16'hDBFF, 1'b0);
        send_unit(16'hDFFF, 1'b0);
        // held high flushed by plain ascii
        send_unit(16'hD834, 1'b0);
        send_unit(16'h0041, 1'b0);
        // held high flushed by another high, which then pairs
        send_unit(16'hDBC0, 1'b0);
        send_unit(16'hDA00, 1'b0);
        send_unit(16'hDD1E, 1'b1);
        // high surrogate as the last unit
        send_unit(16'hDB00, 1'b1);
        // lone low surrogates
        send_unit(16'hDC00, 1'b0);
        send_unit(16'hDFFF, 1'b1);
        // held high, then a last high: six bytes
        send_unit(16'hD800, 1'b0);
        send_unit(16'hDBFF, 1'b1);
        // held high, then a last three byte unit
        send_unit(16'hD801, 1'b0);
        send_unit(16'hFFFF, 1'b1);

        // random strings
        while (units_sent < UNIT_TARGET)
        begin
            if (!hold_done && units_sent >= HOLD_AT)
            begin
                hold_done     = 1'b1;
                long_hold_req = 1'b1;
            end
            if (!pause_done && units_sent >= PAUSE_AT)
            begin
                pause_done = 1'b1;
                code_in.valid <= 1'b0;
                while (sb.expected_count() != 0)
                    @(posedge clk);
            end
            if (units_sent >= CALM_AFTER)
                idle_on = 1'b0;
            send_text($urandom_range(1, 8));
        end
        code_in.valid <= 1'b0;

        // drain and watch for stray bytes
        while (sb.expected_count() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("%0d code units sent, %0d bytes checked", sb.units_seen, sb.bytes_seen);
        $display("%0d surrogate pairs joined, %0d held units flushed alone",
                 sb.pairs_seen, sb.flushes_seen);
        if (sb.errors == 0)
            $display("utf16_to_utf8_stream_encoder_unit_tb passed");
        else
            $display("utf16_to_utf8_stream_encoder_unit_tb failed");
        $finish;
    end

endmodule

// ===== utf16_to_utf8_stream_encoder_unit.f =====
hw/rtl/u16u8_pkg.sv
hw/rtl/u16u8_if.sv
hw/rtl/u16u8_front.sv
hw/rtl/u16u8_queue.sv
hw/rtl/u16u8_back.sv
hw/rtl/utf16_to_utf8_stream_encoder_unit.sv
tb/sv/utf16_to_utf8_stream_encoder_unit_tb_pkg.sv
tb/sv/utf16_to_utf8_stream_encoder_unit_tb.sv
